@@ rtl/fsp_pkg.sv @@
// Shared types, codes and constant tables of the sweep programmer.
// No dependencies; every other file imports this package.
package fsp_pkg;

   // Which fixed six-word init set a command asks for.
   typedef enum logic [1:0] {
      SET_NONE = 2'd0,
      SET_0    = 2'd1,
      SET_1    = 2'd2,
      SET_2    = 2'd3
   } set_sel_type;

   // Control part of one queued command from the front to the back.
   typedef struct packed {
      set_sel_type pre_set;    // Band set sent first on a begin request.
      set_sel_type point_set;  // Set re-sent before a point at a band edge.
      logic        is_done;    // Final beat is a done marker, not a point word.
   } cmd_ctl_type;

   localparam int CTL_BITS = $bits(cmd_ctl_type);

   // Two queue entries; the pointers are one bit wide and wrap by themselves.
   localparam int QUEUE_DEPTH = 2;

   // Init words go out from the highest index down to zero.
   localparam logic [2:0] LAST_WORD_IDX = 3'd5;

   // The remainder field of the register-0 word is twelve bits wide.
   localparam int REM_FIELD_BITS = 12;

   function automatic logic [31:0] init_word(set_sel_type sel, logic [2:0] idx);
      logic [31:0] word;
      word = 32'h0;
      case (idx)
         3'd0: begin
            case (sel)
               SET_0:   word = 32'h1068_0000;
               SET_1:   word = 32'h08FC_0000;
               SET_2:   word = 32'h0FA0_0000;
               default: word = 32'h0;
            endcase
         end
         3'd1: word = 32'h0800_9F41;
         3'd2: word = 32'h0102_8E42;
         3'd3: word = 32'h0000_04B3;
         3'd4: begin
            case (sel)
               SET_0:   word = 32'h0090_4024;
               SET_1:   word = 32'h0080_4024;
               SET_2:   word = 32'h00A0_4024;
               default: word = 32'h0;
            endcase
         end
         3'd5: word = 32'h0058_0005;
         default: word = 32'h0;
      endcase
      return word;
   endfunction

endpackage

@@ rtl/fsp_front.sv @@
// Front end: accepts requests, keeps the sweep state and classifies each
// request into one queued command. Depends on fsp_pkg.
module fsp_front import fsp_pkg::*; #(
   parameter int MODULUS   = 1000,
   parameter int FREQ_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [FREQ_BITS-1:0] req_start_freq,
   input  logic [FREQ_BITS-1:0] req_end_freq,
   input  logic [FREQ_BITS-1:0] req_step_freq,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_ctl_type          q_ctl,
   output logic [FREQ_BITS-1:0] q_freq
);

   localparam logic [31:0] BAND_LOW  = 32'(2200 * MODULUS);
   localparam logic [31:0] BAND_HIGH = 32'(4400 * MODULUS);

   logic [FREQ_BITS-1:0] cur_ff, cur_in;
   logic [FREQ_BITS-1:0] end_ff, end_in;
   logic [FREQ_BITS-1:0] step_ff, step_in;
   logic                 sweeping_ff, sweeping_in;
   logic [FREQ_BITS:0]   next_freq;
   logic [FREQ_BITS-1:0] point;
   logic                 accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;
   assign next_freq = {1'b0, cur_ff} + {1'b0, step_ff};

   always_comb begin
      cur_in      = cur_ff;
      end_in      = end_ff;
      step_in     = step_ff;
      sweeping_in = sweeping_ff;
      q_ctl       = '{pre_set: SET_NONE, point_set: SET_NONE, is_done: 1'b1};
      point       = cur_ff;
      if (req_type == 1'b0) begin
         cur_in  = req_start_freq;
         end_in  = req_end_freq;
         step_in = req_step_freq;
         point   = req_start_freq;
         if (32'(req_start_freq) < BAND_LOW) begin
            q_ctl.pre_set = SET_2;
         end else if (32'(req_start_freq) < BAND_HIGH) begin
            q_ctl.pre_set = SET_0;
         end else begin
            q_ctl.pre_set = SET_1;
         end
         sweeping_in   = (req_start_freq <= req_end_freq);
         q_ctl.is_done = !(req_start_freq <= req_end_freq);
      end else if (sweeping_ff) begin
         if (next_freq <= {1'b0, end_ff}) begin
            cur_in        = next_freq[FREQ_BITS-1:0];
            point         = next_freq[FREQ_BITS-1:0];
            q_ctl.is_done = 1'b0;
         end else begin
            sweeping_in = 1'b0;
         end
      end
      // A point that sits exactly on a band edge re-sends that band's set.
      if (!q_ctl.is_done) begin
         if (32'(point) == BAND_LOW) begin
            q_ctl.point_set = SET_0;
         end else if (32'(point) == BAND_HIGH) begin
            q_ctl.point_set = SET_1;
         end
      end
      q_freq = point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         end_ff      <= '0;
         step_ff     <= '0;
         sweeping_ff <= 1'b0;
      end else if (accept) begin
         cur_ff      <= cur_in;
         end_ff      <= end_in;
         step_ff     <= step_in;
         sweeping_ff <= sweeping_in;
      end
   end

endmodule

@@ rtl/fsp_queue.sv @@
// Two-entry command queue between the front and the back.
// Depends on fsp_pkg for its depth.
module fsp_queue import fsp_pkg::*; #(
   parameter int DATA_BITS = 26
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int CB = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0]        count_ff;

   assign full      = (count_ff == CB'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + CB'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CB'(1);
         end
      end
   end

endmodule

@@ rtl/fsp_back.sv @@
// Back end: plays out queued commands as register words through an output
// register, with a short reciprocal divider for INT and FRAC. Uses fsp_pkg.
module fsp_back import fsp_pkg::*; #(
   parameter int MODULUS   = 1000,
   parameter int FREQ_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cmd_ctl_type          q_ctl,
   input  logic [FREQ_BITS-1:0] q_freq,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_reg_word,
   output logic                 rsp_word_valid,
   output logic                 rsp_sweep_done,
   output logic                 rsp_last
);

   localparam int RB = $clog2(MODULUS);
   localparam logic [RB:0] MOD_EXT = (RB + 1)'(MODULUS);
   localparam logic [FREQ_BITS-1:0] MOD_FB = FREQ_BITS'(MODULUS);
   // Scaled reciprocal of the modulus. The quotient it estimates is either
   // exact or one too small, which the last division step corrects.
   localparam logic [FREQ_BITS-1:0] RECIP =
      FREQ_BITS'((64'd1 << FREQ_BITS) / 64'(MODULUS));
   localparam logic [1:0] DIV_START = 2'd2;

   typedef enum logic [1:0] {
      B_IDLE,
      B_PRE,
      B_MID,
      B_FINAL
   } back_state_type;

   back_state_type           state_ff;
   cmd_ctl_type              ctl_ff;
   logic [2:0]               idx_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              word_ff;
   logic                     word_valid_ff, done_ff, last_ff;
   logic [FREQ_BITS-1:0]     freq_ff;
   logic [FREQ_BITS-1:0]     quo_ff;
   logic [RB-1:0]            rem_ff;
   logic [RB:0]              diff_ff;
   logic [1:0]               div_cnt_ff;
   logic [2*FREQ_BITS-1:0]   recip_prod;
   logic [FREQ_BITS-1:0]     quo_times_mod;
   logic [FREQ_BITS-1:0]     diff_full;
   logic                     load_ok;
   logic                     emit;
   logic [31:0]              point_word;
   back_state_type           after_pre;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == B_IDLE) && q_valid;
   assign after_pre = (ctl_ff.point_set != SET_NONE) ? B_MID : B_FINAL;

   // A new beat is loaded in every word state, except that a point word
   // waits until the divider has finished.
   assign emit = load_ok && ((state_ff == B_PRE) || (state_ff == B_MID)
               || ((state_ff == B_FINAL) && (ctl_ff.is_done || (div_cnt_ff == '0))));

   // Division by the modulus in three steps: the reciprocal product gives a
   // quotient estimate at pickup, the next cycle forms the remainder, and the
   // last one folds a remainder at or above the modulus back into range.
   assign recip_prod    = (2*FREQ_BITS)'(q_freq) * (2*FREQ_BITS)'(RECIP);
   assign quo_times_mod = quo_ff * MOD_FB;
   assign diff_full     = freq_ff - quo_times_mod;

   assign point_word = (32'(quo_ff) << 15)
                     | 32'({REM_FIELD_BITS'(rem_ff), 3'b000});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (q_pop) begin
         freq_ff    <= q_freq;
         quo_ff     <= recip_prod[2*FREQ_BITS-1 -: FREQ_BITS];
         div_cnt_ff <= DIV_START;
      end else begin
         case (div_cnt_ff)
            2'd2: begin
               diff_ff    <= diff_full[RB:0];
               div_cnt_ff <= 2'd1;
            end
            2'd1: begin
               if (diff_ff >= MOD_EXT) begin
                  quo_ff <= quo_ff + FREQ_BITS'(1);
                  rem_ff <= RB'(diff_ff - MOD_EXT);
               end else begin
                  rem_ff <= diff_ff[RB-1:0];
               end
               div_cnt_ff <= 2'd0;
            end
            default: begin
               div_cnt_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_ok) begin
            rsp_valid_ff <= emit;
         end
         case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  ctl_ff <= q_ctl;
                  idx_ff <= LAST_WORD_IDX;
                  if (q_ctl.pre_set != SET_NONE) begin
                     state_ff <= B_PRE;
                  end else if (q_ctl.point_set != SET_NONE) begin
                     state_ff <= B_MID;
                  end else begin
                     state_ff <= B_FINAL;
                  end
               end
            end
            B_PRE: begin
               if (load_ok) begin
                  word_ff       <= init_word(ctl_ff.pre_set, idx_ff);
                  word_valid_ff <= 1'b1;
                  done_ff       <= 1'b0;
                  last_ff       <= 1'b0;
                  if (idx_ff == 3'd0) begin
                     idx_ff   <= LAST_WORD_IDX;
                     state_ff <= after_pre;
                  end else begin
                     idx_ff <= idx_ff - 3'd1;
                  end
               end
            end
            B_MID: begin
               if (load_ok) begin
                  word_ff       <= init_word(ctl_ff.point_set, idx_ff);
                  word_valid_ff <= 1'b1;
                  done_ff       <= 1'b0;
                  last_ff       <= 1'b0;
                  if (idx_ff == 3'd0) begin
                     state_ff <= B_FINAL;
                  end else begin
                     idx_ff <= idx_ff - 3'd1;
                  end
               end
            end
            B_FINAL: begin
               if (ctl_ff.is_done) begin
                  if (load_ok) begin
                     word_ff       <= 32'h0;
                     word_valid_ff <= 1'b0;
                     done_ff       <= 1'b1;
                     last_ff       <= 1'b1;
                     state_ff      <= B_IDLE;
                  end
               end else if (load_ok && (div_cnt_ff == '0)) begin
                  word_ff       <= point_word;
                  word_valid_ff <= 1'b1;
                  done_ff       <= 1'b0;
                  last_ff       <= 1'b1;
                  state_ff      <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_word   = word_ff;
   assign rsp_word_valid = word_valid_ff;
   assign rsp_sweep_done = done_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   a_word_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (word_valid_ff != done_ff))
      else $error("result carries both or neither of word and done");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> last_ff)
      else $error("done marker not flagged as last beat");

   a_div_started: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (div_cnt_ff == DIV_START) && (state_ff != B_IDLE))
      else $error("command popped without starting its division");

   a_point_after_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && last_ff && word_valid_ff)
         |-> (div_cnt_ff == '0))
      else $error("point word sent before the divider finished");
`endif

endmodule

@@ rtl/frac_n_synth_sweep_programmer.sv @@
// Top level of the fractional-N sweep programmer: front, command queue, back.
// Depends on fsp_pkg, fsp_front, fsp_queue and fsp_back.
//
// Usage: each beat on the req_ channel is one request. A begin request
// (req_type 0) loads start, end and step and produces the six init words of
// the start band, then the start point's register-0 word, or a done marker
// when start lies beyond end. An advance request (req_type 1) produces the
// next point's word, or a done marker once the sweep has passed its end. A
// point exactly on a band edge is preceded by that band's six init words.
// Each rsp_ beat carries one word or a done marker; rsp_last marks a request's final beat.
// Timing: a request is taken in the cycle it is offered unless the two-entry
// queue is full, so requests can arrive back to back. The back picks up a
// command, then loads one beat per cycle while the output is not stalled; a
// point word waits on a three-step reciprocal divider and is loaded once the
// divider has finished. Reset idles the sweep with all limits zero and empties
// the queue and the output register. While rsp_stall is high with a valid
// beat out, that beat holds and no new beat is loaded; the front keeps
// accepting until the queue is full, then stalls.
module frac_n_synth_sweep_programmer import fsp_pkg::*; #(
   parameter int MODULUS   = 1000,
   parameter int FREQ_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [FREQ_BITS-1:0] req_start_freq,
   input  logic [FREQ_BITS-1:0] req_end_freq,
   input  logic [FREQ_BITS-1:0] req_step_freq,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_reg_word,
   output logic                 rsp_word_valid,
   output logic                 rsp_sweep_done,
   output logic                 rsp_last
);

   // A queued command is its control struct on top of the point frequency.
   localparam int CMD_BITS = CTL_BITS + FREQ_BITS;

   cmd_ctl_type          push_ctl, pop_ctl;
   logic [FREQ_BITS-1:0] push_freq, pop_freq;
   logic                 q_push, q_full, q_pop, q_not_empty;
   logic [CMD_BITS-1:0]  q_pop_data;

   fsp_front #(
      .MODULUS   (MODULUS),
      .FREQ_BITS (FREQ_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_start_freq (req_start_freq),
      .req_end_freq   (req_end_freq),
      .req_step_freq  (req_step_freq),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_ctl          (push_ctl),
      .q_freq         (push_freq)
   );

   fsp_queue #(
      .DATA_BITS (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_ctl, push_freq}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   assign pop_ctl  = cmd_ctl_type'(q_pop_data[CMD_BITS-1 -: CTL_BITS]);
   assign pop_freq = q_pop_data[FREQ_BITS-1:0];

   fsp_back #(
      .MODULUS   (MODULUS),
      .FREQ_BITS (FREQ_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_ctl          (pop_ctl),
      .q_freq         (pop_freq),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_word   (rsp_reg_word),
      .rsp_word_valid (rsp_word_valid),
      .rsp_sweep_done (rsp_sweep_done),
      .rsp_last       (rsp_last)
   );

endmodule
